// ===== hdl/rsd_pkg.sv =====
`default_nettype none

package rsd_pkg;

    // Varint byte layout.
    localparam int unsigned PAYLOAD_W = 7;
    localparam logic [6:0] PAYLOAD_MASK = 7'h7f;
    localparam int unsigned MORE_BIT = 7;

    // Shift tracking: groups of seven bits, saturating at 63.
    localparam int unsigned SHIFT_W = 6;
    localparam logic [5:0] GROUP_BITS = 6'd7;
    localparam logic [5:0] SHIFT_MAX = 6'd63;
    localparam logic [5:0] SHIFT_SAT_LIMIT = SHIFT_MAX - GROUP_BITS;

    // Relocation type that patches a full 32-bit word.
    localparam logic [31:0] TYPE_WORD32 = 32'd2;

    // A word delta is in units of four bytes.
    localparam int unsigned DELTA_SHIFT = 2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASE   = 1'b0,
        CFG_OFFSET = 1'b1
    } cfg_reg_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] patch_address;
        logic [31:0] add_amount;
        logic        apply;
        logic        table_end;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/relocation_stream_decoder_core.sv =====
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------------
// input     | in        | in_valid / in_stall    | table_byte
// output    | out       | out_valid / out_stall  | patch_address, add_amount, apply, table_end
// config    | in        | cfg_write              | cfg_index, cfg_data
//
// Each byte is decoded in the cycle it is accepted, and its result (if any)
// is registered at that edge, so one byte per cycle is sustained while in_stall is low.
// The running-address adder is the longest path.
// A two-entry output buffer (output register plus skid register) lets input
// continue while one result is stalled; in_stall is the skid register being full.
// Reset (rst_n low, asynchronous) empties both registers and restarts the table decode.
`default_nettype none

module relocation_stream_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Byte input channel.
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  table_byte,
    // Result output channel.
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      patch_address,
    output logic [31:0]      add_amount,
    output logic             apply,
    output logic             table_end,
    // Configuration write port.
    input  wire logic        cfg_write,
    input  wire logic [rsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Configuration registers.
    logic [31:0] base_reg;
    logic [31:0] offset_reg;

    // Decode state.
    logic        expect_delta_reg, expect_delta_next;
    logic [31:0] accum_reg, accum_next;
    logic [rsd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [31:0] running_reg, running_next;
    logic        type_word32_reg, type_word32_next;
    logic        fresh_reg, fresh_next;

    // Output buffer.
    logic             out_valid_reg, out_valid_next;
    rsd_pkg::result_t out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    rsd_pkg::result_t skid_data_reg, skid_data_next;

    // Decode results.
    logic             in_accept;
    logic             out_take;
    logic [31:0]      shifted;
    logic [31:0]      accum_sum;
    logic [31:0]      start_address;
    logic             res_valid;
    rsd_pkg::result_t res_data;

    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == rsd_pkg::CFG_BASE)
                base_reg <= cfg_data;
            else if (cfg_index == rsd_pkg::CFG_OFFSET)
                offset_reg <= cfg_data;
        end
    end

    // Varint accumulation; groups at shift 32 or above are dropped.
    always_comb
    begin
        shifted   = {25'd0, table_byte[6:0] & rsd_pkg::PAYLOAD_MASK} << shift_reg;
        accum_sum = shift_reg[5] ? accum_reg : (accum_reg | shifted);
        // While the table is fresh the base register stands in for the address.
        start_address = fresh_reg ? base_reg : running_reg;
    end

    // Next decode state and the result of the accepted byte.
    always_comb
    begin
        expect_delta_next = expect_delta_reg;
        accum_next        = accum_reg;
        shift_next        = shift_reg;
        running_next      = running_reg;
        type_word32_next  = type_word32_reg;
        fresh_next        = fresh_reg;
        res_valid         = 1'b0;
        res_data          = '0;

        if (in_accept)
        begin
            if (table_byte[rsd_pkg::MORE_BIT])
            begin
                accum_next = accum_sum;
                if (shift_reg <= rsd_pkg::SHIFT_SAT_LIMIT)
                    shift_next = shift_reg + rsd_pkg::GROUP_BITS;
                else
                    shift_next = rsd_pkg::SHIFT_MAX;
            end
            else
            begin
                accum_next = '0;
                shift_next = '0;
                if (!expect_delta_reg)
                begin
                    if (accum_sum == 32'd0)
                    begin
                        // Type zero closes the table.
                        fresh_next         = 1'b1;
                        res_valid          = 1'b1;
                        res_data.table_end = 1'b1;
                    end
                    else
                    begin
                        type_word32_next  = (accum_sum == rsd_pkg::TYPE_WORD32);
                        expect_delta_next = 1'b1;
                    end
                end
                else
                begin
                    running_next = start_address + (accum_sum << rsd_pkg::DELTA_SHIFT);
                    fresh_next        = 1'b0;
                    expect_delta_next = 1'b0;
                    res_valid              = 1'b1;
                    res_data.patch_address = running_next;
                    res_data.add_amount    = offset_reg;
                    res_data.apply         = type_word32_reg;
                end
            end
        end
    end

    // Output register and skid register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                if (res_valid)
                    out_data_next = res_data;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_delta_reg <= 1'b0;
            accum_reg        <= '0;
            shift_reg        <= '0;
            running_reg      <= '0;
            type_word32_reg  <= 1'b0;
            fresh_reg        <= 1'b1;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            expect_delta_reg <= expect_delta_next;
            accum_reg        <= accum_next;
            shift_reg        <= shift_next;
            running_reg      <= running_next;
            type_word32_reg  <= type_word32_next;
            fresh_reg        <= fresh_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_stall      = skid_valid_reg;
    assign out_valid     = out_valid_reg;
    assign patch_address = out_data_reg.patch_address;
    assign add_amount    = out_data_reg.add_amount;
    assign apply         = out_data_reg.apply;
    assign table_end     = out_data_reg.table_end;

endmodule

`default_nettype wire

// ===== hdl/rsd_checker.sv =====
`default_nettype none

module rsd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [7:0]  table_byte,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] patch_address,
    input wire logic [31:0] add_amount,
    input wire logic        apply,
    input wire logic        table_end
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(patch_address)
            && $stable(add_amount) && $stable(apply) && $stable(table_end))
        else $error("stalled result transaction changed");

    // An end-of-table result carries no patch information.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_end |-> patch_address == 32'd0 && add_amount == 32'd0 && !apply)
        else $error("end result with nonzero fields");

    // The input side stalls only while a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // A continuation byte never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && table_byte[7] && !out_valid |=> !out_valid)
        else $error("result from continuation byte");

endmodule

bind relocation_stream_decoder_core rsd_checker u_rsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .table_byte    (table_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .patch_address (patch_address),
    .add_amount    (add_amount),
    .apply         (apply),
    .table_end     (table_end)
);

`default_nettype wire
